// File: rtl/jit_pkg.sv
// ----------------------------------------------------------------------------
// jit_pkg
// Shared types and constants of the job id table: field widths, command
// codes and the structs passed between the sequencer, the slot memory and
// the top level.
// ----------------------------------------------------------------------------
package jit_pkg;

  localparam int CMD_W    = 3;
  localparam int PID_W    = 22;
  localparam int IN_JID_W = 8;
  localparam int JID_W    = 5;
  localparam int ST_W     = 2;
  localparam int SLOT_W   = 4;

  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BY_PID = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BY_JID = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FG     = 3'd4;

  localparam logic [ST_W-1:0] ST_FG = 2'd1;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [JID_W-1:0] jid;
    logic [ST_W-1:0]  st;
  } entry_t;

  typedef struct packed {
    logic   en;
    logic   live;
    entry_t data;
  } mem_wr_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [PID_W-1:0]    pid;
    logic [IN_JID_W-1:0] jid;
    logic [ST_W-1:0]     st;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [PID_W-1:0]  pid;
    logic [JID_W-1:0]  jid;
    logic [ST_W-1:0]   st;
  } res_t;

endpackage

// File: rtl/jit_if.sv
// ----------------------------------------------------------------------------
// jit_in_if / jit_out_if
// Valid/ready channels of the job id table: the command channel and the
// result channel.
// ----------------------------------------------------------------------------
interface jit_in_if;
  logic                          valid;
  logic                          ready;
  logic [jit_pkg::CMD_W-1:0]     command;
  logic [jit_pkg::PID_W-1:0]     process_id;
  logic [jit_pkg::IN_JID_W-1:0]  job_id;
  logic [jit_pkg::ST_W-1:0]      run_state;

  modport source (output valid, command, process_id, job_id, run_state, input ready);
  modport sink (input valid, command, process_id, job_id, run_state, output ready);
endinterface

interface jit_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [jit_pkg::SLOT_W-1:0]    slot;
  logic [jit_pkg::PID_W-1:0]     found_process_id;
  logic [jit_pkg::JID_W-1:0]     found_job_id;
  logic [jit_pkg::ST_W-1:0]      found_state;

  modport source (output valid, ok, slot, found_process_id, found_job_id, found_state,
                  input ready);
  modport sink (input valid, ok, slot, found_process_id, found_job_id, found_state,
                output ready);
endinterface

// File: rtl/jit_mem.sv
// ----------------------------------------------------------------------------
// jit_mem
// Slot memory: one write port and one registered read port. A live bit per
// slot, cleared by reset, makes a slot that was never filled read as zero.
// ----------------------------------------------------------------------------
module jit_mem #(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IW-1:0]    rd_addr,
  output jit_pkg::entry_t  rd_data,
  input  logic [IW-1:0]    wr_addr,
  input  jit_pkg::mem_wr_t wr
);

  jit_pkg::entry_t slot_mem_r [SLOTS];
  logic [SLOTS-1:0] live_r;
  jit_pkg::entry_t  rd_ent_r;
  logic             rd_live_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      slot_mem_r[wr_addr] <= wr.data;
    end
    rd_ent_r <= slot_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= '0;
      rd_live_r <= 1'b0;
    end else begin
      if (wr.en) begin
        live_r[wr_addr] <= wr.live;
      end
      rd_live_r <= live_r[rd_addr];
    end
  end

  assign rd_data = rd_live_r ? rd_ent_r : '0;

endmodule

// File: rtl/jit_scan.sv
// ----------------------------------------------------------------------------
// jit_scan
// Command sequencer: reads every slot once per command, keeps the first
// matching slot and the largest job id of the other slots, and for an add or
// delete that hits, writes the chosen slot and updates the next job id.
// ----------------------------------------------------------------------------
module jit_scan #(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_vld,
  input  jit_pkg::req_t    req,
  output logic             req_rdy,
  output logic [IW-1:0]    rd_addr,
  input  jit_pkg::entry_t  rd_data,
  output logic [IW-1:0]    wr_addr,
  output jit_pkg::mem_wr_t wr,
  output logic             res_vld,
  output jit_pkg::res_t    res,
  input  logic             res_rdy
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_TAIL = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  jit_pkg::req_t             req_r;
  logic [IW-1:0]             cnt_r;
  logic                      chk_vld_r;
  logic [IW-1:0]             chk_idx_r;
  logic                      hit_r;
  logic [IW-1:0]             idx_r;
  jit_pkg::entry_t           ent_r;
  logic [jit_pkg::JID_W-1:0] mx_r;
  logic [jit_pkg::JID_W-1:0] nid_r, nid_nxt;

  logic                      match;
  logic                      take;
  logic                      pre;
  logic                      ok;
  logic                      commit;
  logic [6:0]                idx_w;
  logic [jit_pkg::JID_W:0]   inc;

  always_comb begin
    case (req_r.cmd)
      jit_pkg::CMD_ADD:    match = (rd_data.pid == '0);
      jit_pkg::CMD_DEL:    match = (rd_data.pid == req_r.pid);
      jit_pkg::CMD_BY_PID: match = (rd_data.pid == req_r.pid);
      jit_pkg::CMD_BY_JID: match = ({3'b000, rd_data.jid} == req_r.jid);
      jit_pkg::CMD_FG:     match = (rd_data.st == jit_pkg::ST_FG);
      default:             match = 1'b0;
    endcase
  end

  assign take = chk_vld_r && match && !hit_r;

  always_comb begin
    if (req_r.cmd inside {jit_pkg::CMD_ADD, jit_pkg::CMD_DEL, jit_pkg::CMD_BY_PID}) begin
      pre = (req_r.pid != '0);
    end else if (req_r.cmd == jit_pkg::CMD_BY_JID) begin
      pre = (req_r.jid != '0);
    end else if (req_r.cmd == jit_pkg::CMD_FG) begin
      pre = 1'b1;
    end else begin
      pre = 1'b0;
    end
  end

  assign ok      = pre && hit_r;
  assign res_vld = (state_r == S_FIN);
  assign commit  = res_vld && res_rdy;
  assign req_rdy = (state_r == S_IDLE);
  assign rd_addr = cnt_r;
  assign wr_addr = idx_r;
  assign idx_w   = 7'(idx_r);

  always_comb begin
    res = '0;
    if (ok) begin
      res.ok   = 1'b1;
      res.slot = idx_w[jit_pkg::SLOT_W-1:0];
      if (req_r.cmd == jit_pkg::CMD_ADD) begin
        res.pid = req_r.pid;
        res.jid = nid_r;
        res.st  = req_r.st;
      end else begin
        res.pid = ent_r.pid;
        res.jid = ent_r.jid;
        res.st  = ent_r.st;
      end
    end
  end

  always_comb begin
    wr          = '0;
    wr.en       = commit && ok &&
                  (req_r.cmd == jit_pkg::CMD_ADD || req_r.cmd == jit_pkg::CMD_DEL);
    wr.live     = (req_r.cmd == jit_pkg::CMD_ADD);
    wr.data.pid = req_r.pid;
    wr.data.jid = nid_r;
    wr.data.st  = req_r.st;
  end

  // The next job id wraps to one once it passes the table size.
  always_comb begin
    nid_nxt = nid_r;
    inc     = (req_r.cmd == jit_pkg::CMD_ADD) ? {1'b0, nid_r} + 1'b1 : {1'b0, mx_r} + 1'b1;
    if (wr.en) begin
      nid_nxt = (7'(inc) > 7'(SLOTS)) ? 5'd1 : inc[jit_pkg::JID_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (req_vld) state_nxt = S_SCAN;
      S_SCAN:  if (cnt_r == IW'(SLOTS - 1)) state_nxt = S_TAIL;
      S_TAIL:  state_nxt = S_FIN;
      S_FIN:   if (res_rdy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      nid_r     <= 5'd1;
    end else begin
      state_r   <= state_nxt;
      nid_r     <= nid_nxt;
      chk_vld_r <= (state_r == S_SCAN);
      if (state_r == S_IDLE) begin
        cnt_r <= '0;
        hit_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (take) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= cnt_r;
    if (req_vld && req_rdy) begin
      req_r <= req;
      mx_r  <= '0;
    end else if (take) begin
      idx_r <= chk_idx_r;
      ent_r <= rd_data;
    end else if (chk_vld_r && rd_data.jid > mx_r) begin
      mx_r <= rd_data.jid;
    end
  end

endmodule

// File: rtl/job_id_table.sv
// ----------------------------------------------------------------------------
// job_id_table
// Table of job slots with add, delete, lookup and foreground query commands.
// ----------------------------------------------------------------------------
// Each command reads all SLOTS entries of the slot memory through its single
// read port, one entry per cycle; a new command is taken only once the
// sequencer has handed on the result of the last one. The result sits in
// an output register, so a new command is accepted while it waits. The table
// is empty right after reset; no clearing pass is needed.
module job_id_table #(
  parameter int SLOTS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  jit_in_if.sink  in_ch,
  jit_out_if.source out_ch
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  jit_pkg::req_t    req;
  logic             req_rdy;
  logic [IW-1:0]    rd_addr;
  jit_pkg::entry_t  rd_data;
  logic [IW-1:0]    wr_addr;
  jit_pkg::mem_wr_t wr;
  logic             res_vld;
  jit_pkg::res_t    res;
  logic             res_rdy;
  logic             out_vld_r;
  jit_pkg::res_t    out_r;

  assign req.cmd = in_ch.command;
  assign req.pid = in_ch.process_id;
  assign req.jid = in_ch.job_id;
  assign req.st  = in_ch.run_state;
  assign in_ch.ready = req_rdy;

  jit_scan #(.SLOTS(SLOTS), .IW(IW)) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_vld (in_ch.valid),
    .req     (req),
    .req_rdy (req_rdy),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr      (wr),
    .res_vld (res_vld),
    .res     (res),
    .res_rdy (res_rdy)
  );

  jit_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr      (wr)
  );

  assign res_rdy = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_rdy) begin
      out_vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_rdy) begin
      out_r <= res;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.ok               = out_r.ok;
  assign out_ch.slot             = out_r.slot;
  assign out_ch.found_process_id = out_r.pid;
  assign out_ch.found_job_id     = out_r.jid;
  assign out_ch.found_state      = out_r.st;

  // A rejected or unmatched command reports all fields as zero.
  a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.ok) |-> (out_r.slot == '0 && out_r.pid == '0 &&
                                  out_r.jid == '0 && out_r.st == '0))
    else $error("failed transaction carries nonzero fields");

  // Every successful command refers to a live slot.
  a_ok_live : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.ok) |-> (out_r.pid != '0))
    else $error("successful transaction reports a free slot");

  // The sequencer is busy right after it takes a command.
  a_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (!in_ch.ready && !res_vld))
    else $error("sequencer not busy after accepting a transaction");

endmodule
